@@ rtl/mcs_pkg.sv @@
`default_nettype none
package mcs_pkg;
  localparam int MEM_WORDS_DEF = 4096;
  localparam logic CMD_LOAD = 1'b0;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_ALIGN = 3'd1;
  localparam logic [2:0] ERR_OP    = 3'd2;
  localparam logic [2:0] ERR_FN    = 3'd3;
  localparam logic [2:0] ERR_DIV0  = 3'd4;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BLEZ  = 6'h06;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_XORI  = 6'h0e;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_SYS  = 6'h0c;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;   // write load word into memory
    logic fetch;     // issue memory read at pc
    logic latch_ir;  // capture instruction, read registers
    logic exec;      // evaluate instruction, issue data read
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic commit;    // update state and result registers
    logic load_res;  // result for a load command
  } mcs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_mult;
    logic is_div;
    logic div_last;
    logic mul_last;
  } mcs_stat_t;
endpackage
`default_nettype wire

@@ rtl/mcs_ctrl.sv @@
`default_nettype none
module mcs_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire mcs_pkg::mcs_stat_t stat,
  output mcs_pkg::mcs_cmd_t ctl
);
  import mcs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;

  logic [2:0] state, state_next;
  logic out_valid_next;
  logic acc;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc = in_valid && in_ready;

  always_comb begin
    ctl = '0;
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (cmd == CMD_LOAD) begin
            ctl.load_wr = 1'b1;
            ctl.load_res = 1'b1;
            out_valid_next = 1'b1;
          end else begin
            ctl.fetch = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        ctl.latch_ir = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        ctl.exec = 1'b1;
        ctl.mul_start = stat.is_mult;
        ctl.div_start = stat.is_div;
        state_next = stat.is_mult ? S_MUL : (stat.is_div ? S_DIV : S_EXEC);
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        if (stat.mul_last) state_next = S_WB;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) state_next = S_WB;
      end
      S_EXEC: begin
        state_next = S_WB;
      end
      S_WB: begin
        ctl.commit = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_wb_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |=> out_valid) else $error("commit without result");
  a_fetch_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state == S_DEC)) else $error("bad sequence");
endmodule
`default_nettype wire

@@ rtl/mcs_dp.sv @@
`default_nettype none
module mcs_dp #(
  parameter int MEM_WORDS = mcs_pkg::MEM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mcs_pkg::mcs_cmd_t ctl,
  output mcs_pkg::mcs_stat_t stat,
  input  wire logic [11:0] load_index,
  input  wire logic [31:0] load_word,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic        store_done,
  output logic        syscall_seen,
  output logic [31:0] syscall_code,
  output logic [31:0] syscall_arg,
  output logic [2:0]  error
);
  import mcs_pkg::*;
  localparam int AW = $clog2(MEM_WORDS);

  // load kinds
  localparam logic [2:0] LK_NONE = 3'd0;
  localparam logic [2:0] LK_LB   = 3'd1;
  localparam logic [2:0] LK_LBU  = 3'd2;
  localparam logic [2:0] LK_LH   = 3'd3;
  localparam logic [2:0] LK_LHU  = 3'd4;
  localparam logic [2:0] LK_LW   = 3'd5;

  // store kinds
  localparam logic [1:0] SK_NONE = 2'd0;
  localparam logic [1:0] SK_SB   = 2'd1;
  localparam logic [1:0] SK_SH   = 2'd2;
  localparam logic [1:0] SK_SW   = 2'd3;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;

  logic [31:0] regs [32];
  logic [31:0] pc, hi, lo;
  logic [31:0] ir, a, b;

  // decoded fields
  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, zimm, pc4, ea;
  assign op = ir[31:26];
  assign rs = ir[25:21];
  assign rt = ir[20:16];
  assign rd = ir[15:11];
  assign sh = ir[10:6];
  assign fn = ir[5:0];
  assign imm = ir[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'd0, imm};
  assign pc4 = pc + 32'd4;
  assign ea = a + simm;

  // execute-stage registers
  logic        x_wen;
  logic [4:0]  x_wr;
  logic [31:0] x_wv, x_npc, x_scode, x_sarg;
  logic        x_st, x_sc, x_load;
  logic [2:0]  x_err;
  logic [1:0]  x_lane;
  logic [2:0]  x_lk;
  logic [1:0]  x_sk;
  logic [AW-1:0] x_addr;

  logic        e_wen, e_st, e_sc;
  logic [4:0]  e_wr;
  logic [31:0] e_wv, e_npc;
  logic [2:0]  e_err, e_lk;
  logic [1:0]  e_sk;
  logic        e_mul, e_div;
  logic signed [31:0] sa, sb2;
  assign sa = a;
  assign sb2 = b;

  always_comb begin
    e_wen = 1'b0; e_wr = rt; e_wv = '0; e_npc = pc4; e_st = 1'b0; e_sc = 1'b0;
    e_err = ERR_OK; e_lk = LK_NONE; e_sk = SK_NONE; e_mul = 1'b0; e_div = 1'b0;
    case (op)
      OP_RTYPE: begin
        e_wr = rd;
        case (fn)
          FN_ADD:  begin e_wen = 1'b1; e_wv = a + b; end
          FN_SUB:  begin e_wen = 1'b1; e_wv = a - b; end
          FN_AND:  begin e_wen = 1'b1; e_wv = a & b; end
          FN_OR:   begin e_wen = 1'b1; e_wv = a | b; end
          FN_XOR:  begin e_wen = 1'b1; e_wv = a ^ b; end
          FN_NOR:  begin e_wen = 1'b1; e_wv = ~(a | b); end
          FN_SLT:  begin e_wen = 1'b1; e_wv = {31'd0, sa < sb2}; end
          FN_SLL:  begin e_wen = 1'b1; e_wv = b << sh; end
          FN_SRL:  begin e_wen = 1'b1; e_wv = b >> sh; end
          FN_SRA:  begin e_wen = 1'b1; e_wv = sb2 >>> sh; end
          FN_MFHI: begin e_wen = 1'b1; e_wv = hi; end
          FN_MFLO: begin e_wen = 1'b1; e_wv = lo; end
          FN_JR:   e_npc = a;
          FN_SYS:  e_sc = 1'b1;
          FN_MULT: e_mul = 1'b1;
          FN_DIV:  begin
            if (b == 32'd0) e_err = ERR_DIV0;
            else e_div = 1'b1;
          end
          default: e_err = ERR_FN;
        endcase
      end
      OP_J:    e_npc = {pc4[31:28], ir[25:0], 2'b00};
      OP_JAL:  begin
        e_wen = 1'b1; e_wr = 5'd31; e_wv = pc4;
        e_npc = {pc4[31:28], ir[25:0], 2'b00};
      end
      OP_BEQ:  if (a == b) e_npc = pc4 + {simm[29:0], 2'b00};
      OP_BNE:  if (a != b) e_npc = pc4 + {simm[29:0], 2'b00};
      OP_BLEZ: if (a == 32'd0 || a[31]) e_npc = pc4 + {simm[29:0], 2'b00};
      OP_BGTZ: if (a != 32'd0 && !a[31]) e_npc = pc4 + {simm[29:0], 2'b00};
      OP_ADDI, OP_ADDIU: begin e_wen = 1'b1; e_wv = a + simm; end
      OP_SLTI:  begin e_wen = 1'b1; e_wv = {31'd0, sa < $signed(simm)}; end
      OP_SLTIU: begin e_wen = 1'b1; e_wv = {31'd0, a < simm}; end
      OP_ANDI:  begin e_wen = 1'b1; e_wv = a & zimm; end
      OP_ORI:   begin e_wen = 1'b1; e_wv = a | zimm; end
      OP_XORI:  begin e_wen = 1'b1; e_wv = a ^ zimm; end
      OP_LUI:   begin e_wen = 1'b1; e_wv = {imm, 16'd0}; end
      OP_LB:  begin e_wen = 1'b1; e_lk = LK_LB; end
      OP_LBU: begin e_wen = 1'b1; e_lk = LK_LBU; end
      OP_LH:  if (ea[0]) e_err = ERR_ALIGN; else begin e_wen = 1'b1; e_lk = LK_LH; end
      OP_LHU: if (ea[0]) e_err = ERR_ALIGN; else begin e_wen = 1'b1; e_lk = LK_LHU; end
      OP_LW:  if (ea[1:0] != 2'd0) e_err = ERR_ALIGN;
              else begin e_wen = 1'b1; e_lk = LK_LW; end
      OP_SB:  begin e_st = 1'b1; e_sk = SK_SB; end
      OP_SH:  if (ea[0]) e_err = ERR_ALIGN; else begin e_st = 1'b1; e_sk = SK_SH; end
      OP_SW:  if (ea[1:0] != 2'd0) e_err = ERR_ALIGN;
              else begin e_st = 1'b1; e_sk = SK_SW; end
      default: e_err = ERR_OP;
    endcase
  end

  assign stat.is_mult = e_mul;
  assign stat.is_div  = e_div;

  // multiply: 32x16 partial products over two steps on magnitudes
  logic [31:0] ma, mb;
  logic        neg_q, neg_r;
  logic [63:0] prod;
  logic        mcnt;
  logic [47:0] pp;
  assign pp = ma * (mcnt ? mb[31:16] : mb[15:0]);
  assign stat.mul_last = mcnt;

  // divide: restoring, one bit a step
  logic [31:0] dq, dr;
  logic [4:0]  dcnt;
  logic [32:0] dtrial;
  assign dtrial = {dr, dq[31]} - {1'b0, mb};
  assign stat.div_last = (dcnt == 5'd31);

  logic [31:0] mag_a, mag_b;
  assign mag_a = a[31] ? (32'd0 - a) : a;
  assign mag_b = b[31] ? (32'd0 - b) : b;

  always_ff @(posedge clk) begin
    if (ctl.mul_start || ctl.div_start) begin
      ma <= mag_a; mb <= mag_b;
      neg_q <= a[31] ^ b[31]; neg_r <= a[31];
      prod <= '0; mcnt <= 1'b0;
      dq <= mag_a; dr <= '0; dcnt <= '0;
    end
    if (ctl.mul_step) begin
      if (mcnt) prod <= prod + {pp, 16'd0};
      else prod <= {16'd0, pp};
      mcnt <= 1'b1;
    end
    if (ctl.div_step) begin
      if (!dtrial[32]) begin
        dr <= dtrial[31:0]; dq <= {dq[30:0], 1'b1};
      end else begin
        dr <= {dr[30:0], dq[31]}; dq <= {dq[30:0], 1'b0};
      end
      dcnt <= dcnt + 5'd1;
    end
  end

  // memory port: one read, one write
  always_comb begin
    rd_addr = pc[AW+1:2];
    if (ctl.exec) rd_addr = ea[AW+1:2];
  end

  always_ff @(posedge clk) begin
    if (ctl.fetch || ctl.exec) mem_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  logic [31:0] lane_w;
  assign lane_w = mem_q >> {x_lane, 3'b000};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = x_addr;
    wr_data = mem_q;
    if (ctl.load_wr) begin
      wr_en = 1'b1;
      wr_addr = AW'(load_index);
      wr_data = load_word;
    end else if (ctl.commit && x_sk != SK_NONE) begin
      wr_en = 1'b1;
      case (x_sk)
        SK_SB: wr_data = (mem_q & ~(32'hff << {x_lane, 3'b000}))
                       | ({24'd0, b[7:0]} << {x_lane, 3'b000});
        SK_SH: wr_data = (mem_q & ~(32'hffff << {x_lane, 3'b000}))
                       | ({16'd0, b[15:0]} << {x_lane, 3'b000});
        default: wr_data = b;
      endcase
    end
  end

  logic [31:0] wb_val;
  always_comb begin
    case (x_lk)
      LK_LB:  wb_val = {{24{lane_w[7]}}, lane_w[7:0]};
      LK_LBU: wb_val = {24'd0, lane_w[7:0]};
      LK_LH:  wb_val = {{16{lane_w[15]}}, lane_w[15:0]};
      LK_LHU: wb_val = {16'd0, lane_w[15:0]};
      LK_LW:  wb_val = mem_q;
      default: wb_val = x_wv;
    endcase
  end

  logic wb_en;
  assign wb_en = x_wen && (x_wr != 5'd0);

  always_ff @(posedge clk) begin
    if (ctl.latch_ir) begin
      ir <= mem_q;
      a  <= regs[mem_q[25:21]];
      b  <= regs[mem_q[20:16]];
    end
    if (ctl.exec) begin
      x_wen <= e_wen; x_wr <= e_wr; x_wv <= e_wv; x_npc <= e_npc;
      x_st <= e_st; x_sc <= e_sc; x_err <= e_err;
      x_lk <= e_lk; x_sk <= e_sk; x_lane <= ea[1:0];
      x_addr <= ea[AW+1:2];
      x_scode <= e_sc ? regs[2] : 32'd0;
      x_sarg  <= e_sc ? regs[4] : 32'd0;
      x_load <= e_mul || e_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
      pc <= '0; hi <= '0; lo <= '0;
    end else if (ctl.commit) begin
      if (wb_en) regs[x_wr] <= wb_val;
      pc <= x_npc;
      if (x_load && stat.is_mult) begin
        if (neg_q) begin
          hi <= 32'(((64'd0 - prod) >> 32));
          lo <= 32'(64'd0 - prod);
        end else begin
          hi <= prod[63:32]; lo <= prod[31:0];
        end
      end else if (x_load) begin
        lo <= neg_q ? (32'd0 - dq) : dq;
        hi <= neg_r ? (32'd0 - dr) : dr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      next_pc <= x_npc;
      reg_written <= wb_en;
      reg_index <= wb_en ? x_wr : 5'd0;
      reg_value <= wb_en ? wb_val : 32'd0;
      store_done <= x_st;
      syscall_seen <= x_sc;
      syscall_code <= x_scode;
      syscall_arg <= x_sarg;
      error <= x_err;
    end else if (ctl.load_res) begin
      next_pc <= pc;
      reg_written <= 1'b0; reg_index <= '0; reg_value <= '0;
      store_done <= 1'b0; syscall_seen <= 1'b0;
      syscall_code <= '0; syscall_arg <= '0; error <= ERR_OK;
    end
  end
endmodule
`default_nettype wire

@@ rtl/mips32_subset_core_step.sv @@
`default_nettype none
// Multicycle MIPS32 subset core. A beat with cmd 0 writes load_word to memory
// word load_index and answers in the next cycle; a beat with cmd 1 runs one
// instruction at pc: fetch, decode/register read, execute/data read, then
// writeback. MULT adds two 32x16 partial product steps, and DIV adds a
// restoring divider, one quotient bit a cycle.
// The memory has one read port, shared by instruction fetch and data read,
// which sets the fetch and data read steps.
// One beat is in flight at a time; a result waits in the output register
// until taken, and the next beat is accepted after that.
module mips32_subset_core_step #(
  parameter int MEM_WORDS = mcs_pkg::MEM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [11:0] load_index,
  input  wire logic [31:0] load_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic        store_done,
  output logic        syscall_seen,
  output logic [31:0] syscall_code,
  output logic [31:0] syscall_arg,
  output logic [2:0]  error
);
  import mcs_pkg::*;

  mcs_cmd_t  ctl;
  mcs_stat_t stat;

  mcs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .cmd, .out_valid, .out_ready,
    .stat, .ctl
  );

  mcs_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk, .rst, .ctl, .stat, .load_index, .load_word,
    .next_pc, .reg_written, .reg_index, .reg_value, .store_done,
    .syscall_seen, .syscall_code, .syscall_arg, .error
  );
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

import mcs_pkg::*;

// one step result, as seen on the output beat
typedef struct packed {
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        store_done;
  logic        syscall_seen;
  logic [31:0] syscall_code;
  logic [31:0] syscall_arg;
  logic [2:0]  error;
} step_res_t;

class core_scoreboard;
  bit [31:0] mem [4096];
  bit        mem_ok [4096];   // word has been written by a load beat at least once
  bit [31:0] gpr [32];
  bit [31:0] pc, hi, lo;
  step_res_t pending_q [$];
  int        errors;
  int        checks;

  // advance the core state by one accepted input beat and queue its result
  function void note_beat(bit c, bit [11:0] idx, bit [31:0] w);
    bit [31:0] ir, a, b, simm, imm, ea, pc4, npc, wv, ma, mb, q, r, mw;
    bit [5:0]  op, fn;
    bit [4:0]  rs, rt, rd, sh, wr, lane;
    bit [11:0] wi;
    bit        wen;
    bit [63:0] p;
    step_res_t e;
    e = '0;
    wen = 0;
    wr = 0;
    wv = 0;
    if (c == CMD_LOAD) begin
      mem[idx] = w;
      mem_ok[idx] = 1;
    end else begin
      ir = mem[pc[13:2]];
      pc4 = pc + 4;
      npc = pc4;
      op = ir[31:26];
      rs = ir[25:21];
      rt = ir[20:16];
      rd = ir[15:11];
      sh = ir[10:6];
      fn = ir[5:0];
      imm = {16'h0, ir[15:0]};
      simm = {{16{ir[15]}}, ir[15:0]};
      a = gpr[rs];
      b = gpr[rt];
      ea = a + simm;
      lane = {ea[1:0], 3'b000};
      wi = ea[13:2];
      mw = mem[wi];
      case (op)
        OP_RTYPE: begin
          case (fn)
            FN_ADD:  begin wen = 1; wr = rd; wv = a + b; end
            FN_SUB:  begin wen = 1; wr = rd; wv = a - b; end
            FN_AND:  begin wen = 1; wr = rd; wv = a & b; end
            FN_OR:   begin wen = 1; wr = rd; wv = a | b; end
            FN_XOR:  begin wen = 1; wr = rd; wv = a ^ b; end
            FN_NOR:  begin wen = 1; wr = rd; wv = ~(a | b); end
            FN_SLT:  begin wen = 1; wr = rd; wv = {31'h0, $signed(a) < $signed(b)}; end
            FN_SLL:  begin wen = 1; wr = rd; wv = b << sh; end
            FN_SRL:  begin wen = 1; wr = rd; wv = b >> sh; end
            FN_SRA:  begin wen = 1; wr = rd; wv = $signed(b) >>> sh; end
            FN_MFHI: begin wen = 1; wr = rd; wv = hi; end
            FN_MFLO: begin wen = 1; wr = rd; wv = lo; end
            FN_JR:   npc = a;
            FN_SYS: begin
              e.syscall_seen = 1;
              e.syscall_code = gpr[2];
              e.syscall_arg = gpr[4];
            end
            FN_MULT: begin
              p = 64'($signed(a)) * 64'($signed(b));
              hi = p[63:32];
              lo = p[31:0];
            end
            FN_DIV: begin
              if (b == 0) begin
                e.error = ERR_DIV0;
              end else begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                r = ma % mb;
                if (a[31] ^ b[31]) q = -q;
                if (a[31]) r = -r;
                lo = q;
                hi = r;
              end
            end
            default: e.error = ERR_FN;
          endcase
        end
        OP_J:    npc = {pc4[31:28], ir[25:0], 2'b00};
        OP_JAL: begin
          wen = 1; wr = 31; wv = pc4;
          npc = {pc4[31:28], ir[25:0], 2'b00};
        end
        OP_BEQ:  if (a == b) npc = pc4 + (simm << 2);
        OP_BNE:  if (a != b) npc = pc4 + (simm << 2);
        OP_BLEZ: if (a == 0 || a[31]) npc = pc4 + (simm << 2);
        OP_BGTZ: if (a != 0 && !a[31]) npc = pc4 + (simm << 2);
        OP_ADDI, OP_ADDIU: begin wen = 1; wr = rt; wv = a + simm; end
        OP_SLTI:  begin wen = 1; wr = rt; wv = {31'h0, $signed(a) < $signed(simm)}; end
        OP_SLTIU: begin wen = 1; wr = rt; wv = {31'h0, a < simm}; end
        OP_ANDI:  begin wen = 1; wr = rt; wv = a & imm; end
        OP_ORI:   begin wen = 1; wr = rt; wv = a | imm; end
        OP_XORI:  begin wen = 1; wr = rt; wv = a ^ imm; end
        OP_LUI:   begin wen = 1; wr = rt; wv = imm << 16; end
        OP_LB: begin
          wv = mw >> lane;
          wen = 1; wr = rt; wv = {{24{wv[7]}}, wv[7:0]};
        end
        OP_LBU: begin wen = 1; wr = rt; wv = (mw >> lane) & 32'hff; end
        OP_LH, OP_LHU: begin
          if (ea[0]) begin
            e.error = ERR_ALIGN;
          end else begin
            wv = (mw >> lane) & 32'hffff;
            if (op == OP_LH) wv = {{16{wv[15]}}, wv[15:0]};
            wen = 1; wr = rt;
          end
        end
        OP_LW: begin
          if (ea[1:0] != 0) e.error = ERR_ALIGN;
          else begin wen = 1; wr = rt; wv = mw; end
        end
        OP_SB: begin
          mem[wi] = (mw & ~(32'hff << lane)) | ((b & 32'hff) << lane);
          e.store_done = 1;
        end
        OP_SH: begin
          if (ea[0]) e.error = ERR_ALIGN;
          else begin
            mem[wi] = (mw & ~(32'hffff << lane)) | ((b & 32'hffff) << lane);
            e.store_done = 1;
          end
        end
        OP_SW: begin
          if (ea[1:0] != 0) e.error = ERR_ALIGN;
          else begin mem[wi] = b; e.store_done = 1; end
        end
        default: e.error = ERR_OP;
      endcase
      if (wen && wr != 0) begin
        gpr[wr] = wv;
        e.reg_written = 1;
        e.reg_index = wr;
        e.reg_value = wv;
      end
      pc = npc;
    end
    e.next_pc = pc;
    pending_q.push_back(e);
  endfunction

  function void check_result(step_res_t got);
    step_res_t want;
    bit bad;
    checks++;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result beat %p", got);
      return;
    end
    want = pending_q.pop_front();
    bad = (got.next_pc != want.next_pc) || (got.reg_written != want.reg_written) ||
          (got.reg_index != want.reg_index) || (got.reg_value != want.reg_value) ||
          (got.store_done != want.store_done) || (got.syscall_seen != want.syscall_seen) ||
          (got.syscall_code != want.syscall_code) ||
          (got.syscall_arg != want.syscall_arg) || (got.error != want.error);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: result %0d mismatch", checks);
        $display("  expected %p", want);
        $display("  actual   %p", got);
      end
    end
  endfunction
endclass

module tb_top;
  localparam logic CMD_EXEC = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   NUM_EXEC = 240;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        cmd = 0;
  logic [11:0] load_index = 0;
  logic [31:0] load_word = 0;
  logic        out_valid;
  logic        out_ready = 0;
  step_res_t   res;

  core_scoreboard sb = new();

  int send_idle = 28;   // percent of cycles the source idles before a beat
  int recv_idle = 76;   // percent of cycles the sink stalls
  int exec_cnt = 0;
  int cyc = 0;
  bit held = 0;

  mips32_subset_core_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .load_index(load_index), .load_word(load_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(res.next_pc), .reg_written(res.reg_written),
    .reg_index(res.reg_index), .reg_value(res.reg_value),
    .store_done(res.store_done), .syscall_seen(res.syscall_seen),
    .syscall_code(res.syscall_code), .syscall_arg(res.syscall_arg),
    .error(res.error)
  );

  always #4 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output monitor: a beat moves when valid and ready meet at the edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(res);
  end

  // sink: random stalls, plus one long hold so the core backs up its input
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && sb.checks >= 150) begin
        held = 1;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // instruction encoders
  function automatic bit [31:0] enc_r(bit [4:0] rs, bit [4:0] rt, bit [4:0] rd,
                                      bit [4:0] sh, bit [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic bit [31:0] enc_i(bit [5:0] op, bit [4:0] rs, bit [4:0] rt,
                                      bit [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // one input beat; valid held until taken, lowered only on an idle cycle
  task automatic send_beat(bit c, bit [11:0] idx, bit [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    load_index <= idx;
    load_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(c, idx, w);
  endtask

  // place an instruction at pc (unless reusing a written word) and its data word if unwritten, then step
  task automatic run_instr(bit [31:0] ir, bit reuse);
    bit [31:0] ea;
    ea = sb.gpr[ir[25:21]] + {{16{ir[15]}}, ir[15:0]};
    if (ir[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW} &&
        !sb.mem_ok[ea[13:2]])
      send_beat(CMD_LOAD, ea[13:2], $urandom());
    if (!(reuse && sb.mem_ok[sb.pc[13:2]]))
      send_beat(CMD_LOAD, sb.pc[13:2], ir);
    send_beat(CMD_EXEC, 12'($urandom()), $urandom());
    exec_cnt++;
    if (exec_cnt == NUM_EXEC / 3) begin
      send_idle = 76;
      recv_idle = 28;
    end else if (exec_cnt == 2 * NUM_EXEC / 3) begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  function automatic bit [4:0] pick_reg();
    return ($urandom_range(1)) ? 5'($urandom_range(1, 7)) : 5'($urandom());
  endfunction

  function automatic bit [31:0] rand_instr();
    bit [5:0] ops [23] = '{OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
                          OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
                          OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
                          OP_SB, OP_SH, OP_SW};
    bit [5:0] fns [16] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_SYS, FN_MFHI, FN_MFLO,
                          FN_MULT, FN_DIV, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR,
                          FN_NOR, FN_SLT};
    bit [5:0]  op;
    bit [15:0] imm;
    if ($urandom_range(99) < 6) return $urandom();   // raw noise word
    op = ops[$urandom_range(22)];
    imm = $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(0, 64));
    if (op == OP_RTYPE)
      return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom()),
                   fns[$urandom_range(15)]);
    if (op == OP_J || op == OP_JAL)
      return {op, 26'($urandom())};
    return enc_i(op, pick_reg(), pick_reg(), imm);
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: extremes and special cases
    send_beat(CMD_LOAD, 12'hfff, 32'hffffffff);
    send_beat(CMD_LOAD, 12'h000, 32'h00000000);
    run_instr(enc_i(OP_LUI, 0, 2, 16'h8000), 0);          // r2 = most negative
    run_instr(enc_i(OP_ORI, 0, 3, 16'hffff), 0);          // zero-extended imm
    run_instr(enc_i(OP_ADDI, 0, 4, 16'hffff), 0);         // r4 = -1
    run_instr(enc_r(2, 4, 5, 0, FN_DIV), 0);              // min / -1
    run_instr(enc_r(0, 0, 6, 0, FN_MFHI), 0);
    run_instr(enc_r(0, 0, 7, 0, FN_MFLO), 0);
    run_instr(enc_r(3, 0, 0, 0, FN_DIV), 0);              // divide by zero
    run_instr(enc_r(2, 4, 0, 0, FN_MULT), 0);             // full 64-bit product
    run_instr(enc_r(0, 0, 8, 0, FN_MFHI), 0);
    run_instr(enc_r(0, 2, 9, 31, FN_SRA), 0);             // arithmetic shift
    run_instr(enc_i(OP_SLTIU, 0, 10, 16'hffff), 0);       // unsigned compare
    run_instr(enc_r(4, 4, 0, 0, FN_ADD), 0);              // write to r0 dropped
    run_instr(enc_r(0, 0, 0, 0, FN_SYS), 0);
    run_instr(enc_i(OP_LW, 0, 11, 16'h0102), 0);          // misaligned word
    run_instr(enc_i(OP_LH, 0, 11, 16'h0101), 0);          // odd halfword
    run_instr(enc_i(OP_SB, 0, 4, 16'h0203), 0);           // byte lane merge
    run_instr(enc_i(OP_LB, 0, 12, 16'h0203), 0);
    run_instr(enc_i(OP_SH, 0, 3, 16'h0302), 0);
    run_instr(enc_i(OP_LHU, 0, 13, 16'h0302), 0);
    run_instr({OP_JAL, 26'h3ffffff}, 0);
    run_instr(enc_r(31, 0, 0, 0, FN_JR), 0);
    run_instr(enc_i(OP_BEQ, 0, 0, 16'h8000), 0);          // taken, backward max
    run_instr({6'h3f, 26'h0}, 0);                         // unknown opcode
    run_instr(enc_r(0, 0, 1, 0, 6'h3f), 0);               // unknown funct

    // random: mostly load-then-step pairs, some reruns and stray loads
    while (exec_cnt < NUM_EXEC) begin
      if ($urandom_range(99) < 8)
        send_beat(CMD_LOAD, 12'($urandom()), $urandom());
      run_instr(rand_instr(), $urandom_range(99) < 15);
    end
    in_valid <= 0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ mips32_subset_core_step.f @@
rtl/mcs_pkg.sv
rtl/mcs_ctrl.sv
rtl/mcs_dp.sv
rtl/mips32_subset_core_step.sv
tb/tb_top.sv
